// ===== rtl/core/fqd_pkg.sv =====
// Package for the Q16.16 fixed-point divider: status codes, widths and
// the per-stage pipeline record. No dependencies.
package fqd_pkg;

   // Operand and quotient width.
   localparam int DATA_WIDTH = 32;

   // Quotient bits resolved in each divide stage, and the stage count.
   localparam int STAGE_BITS = 2;
   localparam int NUM_STAGES = DATA_WIDTH / STAGE_BITS;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_DIV0 = 2'd1,
      STATUS_OVF  = 2'd2
   } status_type;

   // Record carried from one pipeline stage to the next. The shift field holds
   // the numerator bits still to be brought down in its upper part and the
   // quotient bits found so far in its lower part.
   typedef struct packed {
      logic                    valid;
      status_type              status;
      logic [DATA_WIDTH-1:0]   divisor;
      logic [DATA_WIDTH-1:0]   remainder;
      logic [DATA_WIDTH-1:0]   shift;
   } stage_type;

endpackage

// ===== rtl/core/fqd_prep.sv =====
// Input stage of the fixed-point divider: classifies the operands and sets up
// the partial remainder for the divide stages. Depends on fqd_pkg.
module fqd_prep
   import fqd_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  logic [DATA_WIDTH-1:0] dividend,
   input  logic [DATA_WIDTH-1:0] divisor,
   output stage_type             stage_out
);

   stage_type  stage_ff;
   stage_type  stage_in;
   logic [DATA_WIDTH-1:0] high_part;

   // The numerator is dividend shifted left by FRAC_BITS. Its upper word becomes
   // the starting remainder; when that is not below the divisor the quotient
   // cannot fit in one word.
   always_comb begin
      high_part         = dividend >> (DATA_WIDTH - FRAC_BITS);
      stage_in.valid    = load;
      stage_in.divisor  = divisor;
      stage_in.remainder = high_part;
      stage_in.shift    = dividend << FRAC_BITS;
      priority if (divisor == '0) begin
         stage_in.status = STATUS_DIV0;
      end else if (high_part >= divisor) begin
         stage_in.status = STATUS_OVF;
      end else begin
         stage_in.status = STATUS_OK;
      end
   end

   // Stage register; only the valid bit is reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.status    <= stage_in.status;
      stage_ff.divisor   <= stage_in.divisor;
      stage_ff.remainder <= stage_in.remainder;
      stage_ff.shift     <= stage_in.shift;
   end

   assign stage_out = stage_ff;

endmodule

// ===== rtl/core/fqd_stage.sv =====
// One restoring-division stage of the fixed-point divider: resolves STAGE_BITS
// quotient bits and registers the record. Depends on fqd_pkg.
module fqd_stage
   import fqd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  stage_type stage_in,
   output stage_type stage_out
);

   stage_type stage_ff;
   logic [DATA_WIDTH-1:0] rem_next_in;
   logic [DATA_WIDTH-1:0] shift_next_in;

   // Bring down one numerator bit per step and subtract the divisor when it fits.
   always_comb begin
      logic [DATA_WIDTH:0] widened;
      logic [DATA_WIDTH:0] diff;
      logic                q_bit;
      rem_next_in   = stage_in.remainder;
      shift_next_in = stage_in.shift;
      for (int i = 0; i < STAGE_BITS; i++) begin
         widened = {rem_next_in, shift_next_in[DATA_WIDTH-1]};
         diff    = widened - {1'b0, stage_in.divisor};
         q_bit   = ~diff[DATA_WIDTH];
         rem_next_in   = q_bit ? diff[DATA_WIDTH-1:0] : widened[DATA_WIDTH-1:0];
         shift_next_in = {shift_next_in[DATA_WIDTH-2:0], q_bit};
      end
   end

   // Stage register; only the valid bit is reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.status    <= stage_in.status;
      stage_ff.divisor   <= stage_in.divisor;
      stage_ff.remainder <= rem_next_in;
      stage_ff.shift     <= shift_next_in;
   end

   assign stage_out = stage_ff;

endmodule

// ===== rtl/core/fixed_point_q16_divider_unit.sv =====
// Unsigned fixed-point divider: quotient = (dividend << FRAC_BITS) / divisor.
// A start transfer passes through one setup stage, 16 divide stages of two
// quotient bits each and one output register before the rsp_valid strobe.
// Throughput is one division per cycle; busy stays low, since nothing stalls.
// Synchronous active-high reset clears all valid bits; payload is not reset.
module fixed_point_q16_divider_unit
   import fqd_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [DATA_WIDTH-1:0] req_dividend,
   input  logic [DATA_WIDTH-1:0] req_divisor,
   output logic                  rsp_valid,
   output logic [DATA_WIDTH-1:0] rsp_quotient,
   output logic [1:0]            rsp_status
);

   stage_type chain [NUM_STAGES+1];

   logic                  rsp_valid_ff;
   logic [DATA_WIDTH-1:0] rsp_quotient_ff;
   logic [DATA_WIDTH-1:0] rsp_quotient_in;
   status_type            rsp_status_ff;

   // The pipeline takes a transfer every cycle.
   assign busy = 1'b0;

   // Operand setup stage.
   fqd_prep #(
      .FRAC_BITS (FRAC_BITS)
   ) u_prep (
      .clock     (clock),
      .reset     (reset),
      .load      (start & ~busy),
      .dividend  (req_dividend),
      .divisor   (req_divisor),
      .stage_out (chain[0])
   );

   // Chain of divide stages.
   for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
      fqd_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .stage_in  (chain[s]),
         .stage_out (chain[s+1])
      );
   end

   // Saturate the quotient for a zero divisor or an overflow.
   assign rsp_quotient_in = (chain[NUM_STAGES].status == STATUS_OK) ?
                            chain[NUM_STAGES].shift : '1;

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= chain[NUM_STAGES].valid;
      end
      rsp_quotient_ff <= rsp_quotient_in;
      rsp_status_ff   <= chain[NUM_STAGES].status;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_quotient = rsp_quotient_ff;
   assign rsp_status   = rsp_status_ff;

endmodule
